FILE: design/ssort_pkg.sv
// ----------------------------------------------------------------------------
// ssort_pkg
// Shared types for the selection sort engine: payload structs and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ssort_pkg;

  localparam int unsigned DataW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    is_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    end_of_run;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // write the incoming value at the fill pointer
    logic start;  // close the batch, rewind the pass counters
    logic scan;   // issue one store read and advance the scan pointer
    logic emit;   // present the minimum, write back the swap, next pass
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;      // fill pointer sits on the last slot
    logic scan_end;  // scan pointer sits on the last element of the batch
    logic pass_end;  // current pass is the final one
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

FILE: design/ssort_ram.sv
// ----------------------------------------------------------------------------
// ssort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssort_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/ssort_ctrl.sv
// ----------------------------------------------------------------------------
// ssort_ctrl
// Sequencer for load, minimum scan and emit phases.
// ----------------------------------------------------------------------------
module ssort_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_is_last_i,
  input  ssort_pkg::dp_stat_t  stat_i,
  output logic                 in_ready_o,
  output ssort_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    StLoad,
    StScan,
    StTail,
    StEmit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StLoad: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i && (in_is_last_i || stat_i.full)) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_end) begin
          state_d = StTail;
        end
      end
      // let the last read of the pass reach the compare
      StTail: state_d = StEmit;
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = stat_i.pass_end ? StLoad : StScan;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StLoad);

endmodule

FILE: design/ssort_dp.sv
// ----------------------------------------------------------------------------
// ssort_dp
// Element store, pass and scan pointers, running minimum and output register.
// ----------------------------------------------------------------------------
module ssort_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssort_pkg::ctrl_cmd_t cmd_i,
  output ssort_pkg::dp_stat_t  stat_o,
  input  ssort_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ssort_pkg::out_item_t out_data_o
);

  localparam int unsigned AddrW = $clog2(MAX_ITEMS);
  localparam int unsigned DataW = ssort_pkg::DataW;

  logic [AddrW-1:0] cnt_q, cnt_d;      // fill pointer
  logic [AddrW-1:0] nlast_q, nlast_d;  // index of the last element in the batch
  logic [AddrW-1:0] pass_q, pass_d;
  logic [AddrW-1:0] scan_q, scan_d;

  logic             rd_valid_q;
  logic             rd_first_q;
  logic [AddrW-1:0] rd_idx_q;

  logic signed [DataW-1:0] min_val_q;
  logic [AddrW-1:0]        min_idx_q;
  logic [DataW-1:0]        first_val_q;

  logic                 out_valid_q;
  ssort_pkg::out_item_t out_data_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [DataW-1:0] ram_rdata;

  // Load and swap write-back never coincide
  always_comb begin
    ram_we    = cmd_i.load | cmd_i.emit;
    ram_waddr = cmd_i.emit ? min_idx_q : cnt_q;
    ram_wdata = cmd_i.emit ? first_val_q : DataW'(in_data_i.value);
  end

  ssort_ram #(
    .Width (DataW),
    .Depth (MAX_ITEMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    cnt_d   = cnt_q;
    nlast_d = nlast_q;
    pass_d  = pass_q;
    scan_d  = scan_q;
    if (cmd_i.load) begin
      cnt_d = cnt_q + AddrW'(1);
    end
    if (cmd_i.start) begin
      cnt_d   = '0;
      nlast_d = cnt_q;
      pass_d  = '0;
      scan_d  = '0;
    end
    if (cmd_i.scan) begin
      scan_d = scan_q + AddrW'(1);
    end
    if (cmd_i.emit) begin
      pass_d = pass_q + AddrW'(1);
      scan_d = pass_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      nlast_q     <= '0;
      pass_q      <= '0;
      scan_q      <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q      <= cnt_d;
      nlast_q    <= nlast_d;
      pass_q     <= pass_d;
      scan_q     <= scan_d;
      rd_valid_q <= cmd_i.scan;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Running minimum; strict less-than keeps the first minimum found
  always_ff @(posedge clk_i) begin
    rd_first_q <= (scan_q == pass_q);
    rd_idx_q   <= scan_q;
    if (rd_valid_q) begin
      if (rd_first_q) begin
        min_val_q   <= $signed(ram_rdata);
        min_idx_q   <= rd_idx_q;
        first_val_q <= ram_rdata;
      end else if ($signed(ram_rdata) < min_val_q) begin
        min_val_q <= $signed(ram_rdata);
        min_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.emit) begin
      out_data_q.sorted_value <= min_val_q;
      out_data_q.end_of_run   <= (pass_q == nlast_q);
    end
  end

  always_comb begin
    stat_o.full     = (cnt_q == AddrW'(MAX_ITEMS - 1));
    stat_o.scan_end = (scan_q == nlast_q);
    stat_o.pass_end = (pass_q == nlast_q);
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/selection_sort_engine_core.sv
// ----------------------------------------------------------------------------
// selection_sort_engine_core
// Batch sorter: loads signed 32-bit values, sorts them ascending and streams
// them out smallest first.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o / in_data_i): each transfer loads
//   one value. A transfer with is_last set closes the batch; so does the
//   transfer that fills slot MAX_ITEMS-1, whatever its is_last bit.
//   Output channel (out_valid_o / out_ready_i / out_data_o): one transfer per
//   batch element, ascending signed order, end_of_run set on the final one.
//   Timing: values load one per cycle. Each output
//   pass k (0-based) re-scans the unsorted tail through the
//   single read port of the element store, one element per cycle; then a
//   tail step lets the registered read reach the compare, and an emit step
//   presents the minimum and writes back the swap. Input is held off
//   (in_ready_o low) from the closing transfer until the final result is
//   in the output register.
//   Reset: the fill count, pointers and output valid clear; the store is not
//   cleared, as only entries written in the current batch are read.
//   Stall: a held result stays in the output register and the next pass
//   waits in its emit step until the register is taken; nothing is dropped.
// ----------------------------------------------------------------------------
module selection_sort_engine_core #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ssort_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ssort_pkg::out_item_t out_data_o
);

  // command and status between the sequencer and the datapath
  ssort_pkg::ctrl_cmd_t cmd;
  ssort_pkg::dp_stat_t  stat;

  // Sequencer: load, scan for the minimum, emit, repeat per pass
  ssort_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_is_last_i (in_data_i.is_last),
    .stat_i       (stat),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  // Datapath: element store, running minimum and output register
  ssort_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: design/ssort_checker.sv
// ----------------------------------------------------------------------------
// ssort_checker
// Port-level checks for the selection sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module ssort_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input ssort_pkg::in_item_t  in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input ssort_pkg::out_item_t out_data_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Closing a batch with is_last stops further loads while the sort runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.is_last |=> !in_ready_o)
    else $error("input accepted straight after batch close");

  // No loading while a batch is only partly delivered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_of_run |-> !in_ready_o)
    else $error("input ready in the middle of a batch");

  // Hold an offered input, unchanged, until it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("offered input changed or withdrawn before transfer");

endmodule

bind selection_sort_engine_core ssort_checker u_ssort_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: bench/selection_sort_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selection_sort_engine_core_test
// Self-checking bench for the batch sorter. Batches of signed values go in
// through the input channel. A behavioural sorter in the bench predicts the
// ascending stream for each batch, and every output transfer is compared
// with the oldest prediction.
// A short directed table comes first. It covers single-value batches at the
// extremes and near zero, ties, descending and ascending runs. Random batches
// follow. Two of them fill the store: one has the last flag clear and one has
// it set on the final value. Both channels idle at random throughout.
// ----------------------------------------------------------------------------
module selection_sort_engine_core_test;

  typedef logic signed [ssort_pkg::DataW-1:0] word_t;

  typedef struct {
    ssort_pkg::in_item_t  item;
    bit                   typed;  // want below is the literal result of this row
    ssort_pkg::out_item_t want;
  } stim_row_t;

  localparam int unsigned MaxItems     = 64;
  localparam int unsigned RandomItems  = 160;
  localparam int unsigned DirectedRows = 19;
  localparam word_t       MinVal       = 32'sh8000_0000;
  localparam word_t       MaxVal       = 32'sh7fff_ffff;
  localparam word_t       AllOnes      = 32'shffff_ffff;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  ssort_pkg::in_item_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  ssort_pkg::out_item_t out_data_o;

  // Values loaded in the open batch, and sorted values still owed by the dut
  word_t                open_batch[$];
  ssort_pkg::out_item_t sorted_due[$];
  ssort_pkg::out_item_t due_head;
  int unsigned          mismatches;
  bit                   drain_quiet;

  // Directed table: single-value batches carry their result inline, the rest
  // are predicted.
  stim_row_t directed_rows [DirectedRows] = '{
    '{'{MinVal, 1'b1}, 1'b1, '{MinVal, 1'b1}},
    '{'{MaxVal, 1'b1}, 1'b1, '{MaxVal, 1'b1}},
    '{'{32'sd0, 1'b1}, 1'b1, '{32'sd0, 1'b1}},
    '{'{AllOnes, 1'b1}, 1'b1, '{AllOnes, 1'b1}},
    // extremes mixed with repeated values
    '{'{32'sd5, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{-32'sd3, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd5, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{MaxVal, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{MinVal, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{-32'sd3, 1'b1}, 1'b0, '{32'sd0, 1'b0}},
    // strictly descending: the first two passes swap, the later ones do not
    '{'{32'sd3, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd2, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd1, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd0, 1'b1}, 1'b0, '{32'sd0, 1'b0}},
    // two equal values
    '{'{32'sd7, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd7, 1'b1}, 1'b0, '{32'sd0, 1'b0}},
    // already in order: no swap at all
    '{'{-32'sd2, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{-32'sd1, 1'b0}, 1'b0, '{32'sd0, 1'b0}},
    '{'{32'sd0, 1'b1}, 1'b0, '{32'sd0, 1'b0}}
  };

  selection_sort_engine_core #(
    .MAX_ITEMS (MaxItems)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Load one value into the open batch; on the closing transfer sort the
  // batch and queue the whole ascending stream.
  function automatic void predict_transfer(ssort_pkg::in_item_t it);
    word_t       work[$];
    word_t       swap_val;
    int unsigned n;
    int unsigned min_at;
    open_batch.push_back(it.value);
    if (!it.is_last && open_batch.size() < MaxItems) return;
    work = open_batch;
    n = work.size();
    for (int unsigned i = 0; i + 1 < n; i++) begin
      min_at = i;
      // strict less-than keeps the first minimum on ties
      for (int unsigned j = i + 1; j < n; j++) begin
        if (work[j] < work[min_at]) min_at = j;
      end
      if (min_at != i) begin
        swap_val     = work[i];
        work[i]      = work[min_at];
        work[min_at] = swap_val;
      end
    end
    for (int unsigned k = 0; k < n; k++) begin
      sorted_due.push_back('{sorted_value: work[k], end_of_run: (k + 1 == n)});
    end
    open_batch.delete();
  endfunction

  // Mostly back to back, sometimes a short gap, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Bias towards ties, small magnitudes and the two ends of the range
  function automatic word_t draw_value();
    case ($urandom_range(0, 9))
      4, 5: begin
        return int'($urandom_range(0, 16)) - 8;
      end
      6: begin
        return $urandom_range(0, 1) ? MaxVal : MinVal;
      end
      7: begin
        return MinVal + int'($urandom_range(0, 3));
      end
      8: begin
        return MaxVal - int'($urandom_range(0, 3));
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  // Hold valid low for the gap, then offer the item and hold it until the
  // transfer. Valid stays high into the next call when that has no gap.
  task automatic push_item(input ssort_pkg::in_item_t it, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_transfer(it);
  endtask

  // Output side: take a result, then stall for a random while. Now and then
  // switch to a calm stretch with ready held high.
  initial begin : drain_ctrl
    int unsigned hold;
    hold        = 0;
    drain_quiet = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 49) == 0) drain_quiet = ~drain_quiet;
        hold = drain_quiet ? 0 : gap_len();
      end
    end
  end

  // Compare every output transfer with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sorted_due.size() == 0) begin
        $error("unexpected result: sorted_value %0d end_of_run %0b",
               out_data_o.sorted_value, out_data_o.end_of_run);
        mismatches++;
      end else begin
        due_head = sorted_due.pop_front();
        if (out_data_o.sorted_value !== due_head.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d",
                 due_head.sorted_value, out_data_o.sorted_value);
          mismatches++;
        end
        if (out_data_o.end_of_run !== due_head.end_of_run) begin
          $error("end_of_run: expected %0b, got %0b",
                 due_head.end_of_run, out_data_o.end_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    ssort_pkg::in_item_t it;
    int unsigned         sent;
    int unsigned         batch_no;
    int unsigned         batch_len;
    bit                  flag_on_fill;
    bit                  quiet;
    mismatches = 0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table; a typed row replaces its own prediction
    foreach (directed_rows[r]) begin
      push_item(directed_rows[r].item, gap_len());
      if (directed_rows[r].typed) sorted_due[sorted_due.size() - 1] = directed_rows[r].want;
    end

    // Random batches. The second fills the store with the flag clear, the
    // sixth fills it with the flag set on the final value.
    sent     = 0;
    batch_no = 0;
    while (sent < RandomItems) begin
      quiet        = ($urandom_range(0, 3) == 0);
      flag_on_fill = 1'b1;
      if (batch_no == 1) begin
        batch_len    = MaxItems;
        flag_on_fill = 1'b0;
      end else if (batch_no == 5) begin
        batch_len = MaxItems;
      end else if ($urandom_range(0, 7) == 0) begin
        batch_len = $urandom_range(11, 24);
      end else begin
        batch_len = $urandom_range(1, 10);
      end
      for (int unsigned k = 0; k < batch_len; k++) begin
        it.value   = draw_value();
        it.is_last = (k + 1 == batch_len) ? flag_on_fill : 1'b0;
        push_item(it, quiet ? 0 : gap_len());
      end
      sent += batch_len;
      batch_no++;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then linger long enough for any stray result to show
    while (sorted_due.size() != 0) @(posedge clk_i);
    repeat (MaxItems + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("selection_sort_engine_core test passed");
    end else begin
      $display("selection_sort_engine_core test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("selection_sort_engine_core test failed");
    $finish;
  end

endmodule
